FILE: rtl/ake_pkg.sv
// ----------------------------------------------------------------------------
// altitude estimator package
// shared constants, register indexes and types for the estimator blocks
// ----------------------------------------------------------------------------
package ake_pkg;

  localparam logic [19:0] DtMin     = 20'd105;
  localparam logic [19:0] DtMax     = 20'd104857;
  localparam logic [33:0] SMin      = 34'd66;
  localparam logic [15:0] GainBaro  = 16'd6554;
  localparam logic [15:0] GainRange = 16'd9830;
  localparam logic [16:0] OneQ16    = 17'd65536;

  localparam logic [2:0] RegGravity  = 3'd0;
  localparam logic [2:0] RegQ        = 3'd1;
  localparam logic [2:0] RegBaroR    = 3'd2;
  localparam logic [2:0] RegRangeR   = 3'd3;
  localparam logic [2:0] RegMaxSpeed = 3'd4;

  localparam int unsigned QDepth = 2;

  typedef struct packed {
    logic signed [31:0] accel;
    logic [19:0]        dt;
    logic signed [31:0] baro;
    logic               bvalid;
    logic [30:0]        rng;
    logic               rvalid;
    logic               taken;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PRED1, ST_PRED2, ST_PRED3, ST_CSEL, ST_CDIV, ST_CMUL,
    ST_CUPD, ST_CVEL, ST_CLAMP, ST_OUT
  } state_e;

endpackage

FILE: rtl/altitude_kalman_estimator.sv
// each correction runs the gain divider, except when the innovation sum is below SMin,
// in which case the gain is zero and the divider is skipped; an ignored step skips
// prediction and corrections and goes straight to the output
// the back end takes a new item only after the last result has left its sequencer
// reset: estimates cleared, variance set to one, registers cleared to zero
// ----------------------------------------------------------------------------
// altitude kalman estimator
// top level: configuration registers, front queue and back end sequencer
// ----------------------------------------------------------------------------
module altitude_kalman_estimator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid,
  output logic         s_tready,
  // vertical_accel, step_time, baro_altitude, baro_valid, range_distance,
  // range_valid, zero fill
  input  logic [119:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // altitude, vertical_speed, zero fill
  output logic [63:0]  m_tdata,
  // step_taken, baro_used, range_used
  output logic [2:0]   m_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [30:0]  cfg_data_i
);
  import ake_pkg::*;

  logic [30:0] grav_q, qn_q, br_q, rr_q, ms_q;
  logic        qv, qr;
  item_t       qi;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q <= '0; qn_q <= '0; br_q <= '0; rr_q <= '0; ms_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegGravity:  grav_q <= cfg_data_i;
        RegQ:        qn_q   <= cfg_data_i;
        RegBaroR:    br_q   <= cfg_data_i;
        RegRangeR:   rr_q   <= cfg_data_i;
        RegMaxSpeed: ms_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ake_front u_front (
    .clk_i, .rst_ni, .s_tvalid_i(s_tvalid), .s_tready_o(s_tready),
    .s_tdata_i(s_tdata), .q_valid_o(qv), .q_ready_i(qr), .q_item_o(qi)
  );

  ake_back u_back (
    .clk_i, .rst_ni, .q_valid_i(qv), .q_ready_o(qr), .q_item_i(qi),
    .gravity_i(grav_q), .q_noise_i(qn_q), .baro_r_i(br_q), .range_r_i(rr_q),
    .max_speed_i(ms_q), .m_tvalid_o(m_tvalid), .m_tready_i(m_tready),
    .m_tdata_o(m_tdata), .m_tuser_o(m_tuser)
  );
endmodule

FILE: rtl/ake_front.sv
// ----------------------------------------------------------------------------
// altitude estimator front end
// accepts sensor transactions, classifies the step time, queues the items
// ----------------------------------------------------------------------------
module ake_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  input  logic [119:0]  s_tdata_i,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output ake_pkg::item_t q_item_o
);
  import ake_pkg::*;

  item_t       mem_q [QDepth];
  logic        wp_q, wp_d, rp_q, rp_d;
  logic [1:0]  cnt_q, cnt_d;
  item_t       it;
  logic        push, pop;

  always_comb begin
    it.accel  = s_tdata_i[31:0];
    it.dt     = s_tdata_i[51:32];
    it.baro   = s_tdata_i[83:52];
    it.bvalid = s_tdata_i[84];
    it.rng    = s_tdata_i[115:85];
    it.rvalid = s_tdata_i[116];
    it.taken  = (it.dt >= DtMin) && (it.dt <= DtMax);
  end

  assign s_tready_o = (cnt_q != 2'(QDepth));
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rp_q];
  assign push       = s_tvalid_i && s_tready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      wp_q <= wp_d; rp_q <= rp_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= it;
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'(QDepth) |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !pop) else $error("queue underflow");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QDepth)) else $error("queue count out of range");
`endif
endmodule

FILE: rtl/ake_div.sv
// ----------------------------------------------------------------------------
// altitude estimator gain divider
// restoring divider, one quotient bit per cycle, for the kalman gain
// ----------------------------------------------------------------------------
module ake_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] pq_i,
  input  logic [33:0] s_i,
  output logic        done_o,
  output logic [16:0] k_o
);
  import ake_pkg::*;

  logic [34:0] rem_q, rem_d;
  logic [33:0] den_q;
  logic [48:0] num_q, num_d;
  logic [16:0] quo_q, quo_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [34:0] trial;

  always_comb begin
    trial  = {rem_q[33:0], num_q[48]};
    rem_d  = rem_q; num_d = num_q; quo_d = quo_q; cnt_d = cnt_q; busy_d = busy_q;
    if (start_i) begin
      rem_d = '0; num_d = {pq_i, 16'd0}; quo_d = '0; cnt_d = 6'd49; busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[47:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[15:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[15:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; num_q <= num_d; quo_q <= quo_d;
    if (start_i) den_q <= s_i;
  end

  assign done_o = busy_q && (cnt_q == 6'd1);
  assign k_o    = quo_d;

`ifndef SYNTH
  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> quo_q <= 17'(OneQ16)) else $error("gain above one");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_q) else $error("divider still busy");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cnt_q != 6'd1 |-> !start_i) else $error("divider restarted");
`endif
endmodule

FILE: rtl/ake_back.sv
// ----------------------------------------------------------------------------
// altitude estimator back end
// prediction, scalar corrections and clamps, one step through a sequencer
// ----------------------------------------------------------------------------
module ake_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  output logic           q_ready_o,
  input  ake_pkg::item_t q_item_i,
  input  logic [30:0]    gravity_i,
  input  logic [30:0]    q_noise_i,
  input  logic [30:0]    baro_r_i,
  input  logic [30:0]    range_r_i,
  input  logic [30:0]    max_speed_i,
  output logic           m_tvalid_o,
  input  logic           m_tready_i,
  output logic [63:0]    m_tdata_o,
  output logic [2:0]     m_tuser_o
);
  import ake_pkg::*;

  state_e state_q, state_d;
  item_t  it_q;
  logic signed [33:0] alt_q, alt_d, vel_q, vel_d;
  logic [31:0]        p_q, p_d;
  logic signed [33:0] a_q, a_d, dv_q, dv_d, t1_q, t1_d;
  logic               phase_q, phase_d;
  logic [16:0]        k_q, k_d;
  logic signed [33:0] c_q, c_d;
  logic [63:0]        tdata_q, tdata_d;
  logic [2:0]         tuser_q, tuser_d;
  logic               div_start, div_done;
  logic [16:0]        div_k;
  logic [32:0]        pq;
  logic [33:0]        s_sum;
  logic signed [33:0] z;
  logic signed [66:0] prod;
  logic signed [33:0] sh20, sh21;
  logic [48:0]        pprod;
  logic signed [33:0] lim;

  function automatic logic signed [33:0] sat32(input logic signed [35:0] x);
    if (x > 36'sd2147483647) return 34'sd2147483647;
    if (x < -36'sd2147483648) return -34'sd2147483648;
    return 34'(x);
  endfunction

  assign pq    = 33'(p_q) + 33'(q_noise_i);
  assign s_sum = 34'(pq) + 34'(phase_q ? range_r_i : baro_r_i);
  assign z     = phase_q ? 34'($signed({1'b0, it_q.rng})) : 34'(it_q.baro);
  assign lim   = 34'($signed({1'b0, max_speed_i}));

  ake_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .pq_i(pq), .s_i(s_sum),
    .done_o(div_done), .k_o(div_k)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (q_valid_i) state_d = ST_PRED1;
      ST_PRED1: state_d = it_q.taken ? ST_PRED2 : ST_OUT;
      ST_PRED2: state_d = ST_PRED3;
      ST_PRED3: state_d = ST_CSEL;
      ST_CSEL: begin
        if ((phase_q ? it_q.rvalid : it_q.bvalid) == 1'b0)
          state_d = phase_q ? ST_CLAMP : ST_CSEL;
        else if (s_sum < SMin) state_d = ST_CMUL;
        else state_d = ST_CDIV;
      end
      ST_CDIV:  if (div_done) state_d = ST_CMUL;
      ST_CMUL:  state_d = ST_CUPD;
      ST_CUPD:  state_d = ST_CVEL;
      ST_CVEL:  state_d = phase_q ? ST_CLAMP : ST_CSEL;
      ST_CLAMP: state_d = ST_OUT;
      ST_OUT:   if (!m_tvalid_o || m_tready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready_o = (state_q == ST_IDLE);
    div_start = (state_q == ST_CSEL) && (phase_q ? it_q.rvalid : it_q.bvalid)
                && (s_sum >= SMin);
    alt_d = alt_q; vel_d = vel_q; p_d = p_q; a_d = a_q; dv_d = dv_q; t1_d = t1_q;
    phase_d = phase_q; k_d = k_q; c_d = c_q;
    tdata_d = tdata_q; tuser_d = tuser_q;
    prod = '0; pprod = '0;
    sh20 = '0; sh21 = '0;
    case (state_q)
      ST_PRED1: begin
        a_d = 34'(it_q.accel) - 34'($signed({1'b0, gravity_i}));
        phase_d = 1'b0;
      end
      ST_PRED2: begin
        prod = 67'(a_q) * 67'($signed({1'b0, it_q.dt}));
        sh20 = 34'(prod >>> 20);
        dv_d = sh20;
        prod = 67'(vel_q) * 67'($signed({1'b0, it_q.dt}));
        t1_d = 34'(prod >>> 20);
      end
      ST_PRED3: begin
        prod = 67'(dv_q) * 67'($signed({1'b0, it_q.dt}));
        sh21 = 34'(prod >>> 21);
        alt_d = sat32(36'(alt_q) + 36'(t1_q) + 36'(sh21));
        vel_d = sat32(36'(vel_q) + 36'(dv_q));
        p_d = pq[32] ? 32'hFFFF_FFFF : pq[31:0];
      end
      ST_CSEL: begin
        k_d = '0;
        if ((phase_q ? it_q.rvalid : it_q.bvalid) == 1'b0) phase_d = 1'b1;
      end
      ST_CDIV: if (div_done) k_d = div_k;
      ST_CMUL: begin
        prod = 67'($signed({1'b0, k_q})) * 67'(z - alt_q);
        c_d = 34'(prod >>> 16);
      end
      ST_CUPD: begin
        alt_d = sat32(36'(alt_q) + 36'(c_q));
        prod = 67'(c_q) * 67'($signed({1'b0, phase_q ? GainRange : GainBaro}));
        t1_d = 34'(prod >>> 16);
      end
      ST_CVEL: begin
        vel_d = sat32(36'(vel_q) + 36'(t1_q));
        pprod = 49'(p_q) * 49'(OneQ16 - k_q);
        p_d = pprod[47:16];
        phase_d = 1'b1;
      end
      ST_CLAMP: begin
        if (vel_q > lim) vel_d = lim;
        else if (vel_q < -lim) vel_d = -lim;
        if (alt_q < 0) begin
          alt_d = '0;
          if (vel_q < 0) vel_d = '0;
          else if (vel_q > lim) vel_d = lim;
        end
      end
      ST_OUT: begin
        if (!m_tvalid_o || m_tready_i) begin
          tdata_d = {1'b0, vel_q[31:0], alt_q[30:0]};
          tuser_d = {it_q.taken & it_q.rvalid, it_q.taken & it_q.bvalid, it_q.taken};
        end
      end
      default: ;
    endcase
  end

  logic tvalid_q, tvalid_d;
  always_comb begin
    tvalid_d = tvalid_q;
    if (m_tready_i) tvalid_d = 1'b0;
    if (state_q == ST_OUT && (!tvalid_q || m_tready_i)) tvalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; alt_q <= '0; vel_q <= '0; p_q <= 32'h0001_0000;
      tvalid_q <= 1'b0; phase_q <= 1'b0;
    end else begin
      state_q <= state_d; alt_q <= alt_d; vel_q <= vel_d; p_q <= p_d;
      tvalid_q <= tvalid_d; phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_valid_i && q_ready_o) it_q <= q_item_i;
    a_q <= a_d; dv_q <= dv_d; t1_q <= t1_d; k_q <= k_d; c_q <= c_d;
    tdata_q <= tdata_d; tuser_q <= tuser_d;
  end

  assign m_tvalid_o = tvalid_q;
  assign m_tdata_o  = tdata_q;
  assign m_tuser_o  = tuser_q;

`ifndef SYNTH
  a_alt_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT |-> alt_q >= 0) else $error("negative altitude out");
  a_speed_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT && it_q.taken |-> vel_q <= lim && vel_q >= -lim)
    else $error("speed above limit");
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tuser_o[0] |-> m_tuser_o[2:1] == 2'b00)
    else $error("used flag on ignored step");
`endif
endmodule

FILE: verif/altitude_kalman_estimator_test.sv
// ----------------------------------------------------------------------------
// altitude kalman estimator testbench
// streams acceleration and sensor samples through the estimator under several
// register settings and idling patterns, predicts every result in fixed point
// and compares altitude, speed and the step and sensor flags field by field
// ----------------------------------------------------------------------------
module altitude_kalman_estimator_test;
  import ake_pkg::*;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned SettleCycles = 150;
  localparam logic [2:0] RegUnused = 3'd6;

  typedef struct {
    logic signed [31:0] accel;
    logic [19:0]        dt;
    logic signed [31:0] baro;
    logic               bvalid;
    logic [30:0]        rng;
    logic               rvalid;
  } sample_t;

  typedef struct {
    logic [30:0]        alt;
    logic signed [31:0] spd;
    logic               taken;
    logic               baro_used;
    logic               range_used;
  } estimate_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_tvalid;
  logic         s_tready;
  logic [119:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [63:0]  m_tdata;
  logic [2:0]   m_tuser;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i;
  logic [30:0]  cfg_data_i;

  sample_t   pending_samples[$];
  sample_t   sample_on_bus;
  estimate_t expected_estimates[$];

  longint reg_val[5];
  longint est_alt, est_spd, est_var;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_req;
  int unsigned hold_cnt;
  int unsigned quiet_cycles;
  int unsigned error_count;
  bit          sample_taken;
  bit          cfg_done;

  altitude_kalman_estimator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic void fuse_measurement(longint z, longint r, longint g);
    longint pq, s, k, c;
    pq = est_var + reg_val[RegQ];
    s = pq + r;
    k = 0;
    if (s >= longint'(SMin)) k = (pq <<< 16) / s;
    c = (k * (z - est_alt)) >>> 16;
    est_alt = sat32(est_alt + c);
    est_spd = sat32(est_spd + ((c * g) >>> 16));
    est_var = (est_var * (longint'(OneQ16) - k)) >>> 16;
  endfunction

  function automatic estimate_t predict_estimate(sample_t sm);
    estimate_t e;
    longint a, d, dv, p, lim;
    logic taken;
    taken = (sm.dt >= DtMin) && (sm.dt <= DtMax);
    if (taken) begin
      a = longint'(sm.accel) - reg_val[RegGravity];
      d = longint'(sm.dt);
      dv = (a * d) >>> 20;
      lim = reg_val[RegMaxSpeed];
      est_alt = sat32(est_alt + ((est_spd * d) >>> 20) + ((dv * d) >>> 21));
      est_spd = sat32(est_spd + dv);
      p = est_var + reg_val[RegQ];
      est_var = (p > 64'sh0FFFFFFFF) ? 64'sh0FFFFFFFF : p;
      if (sm.bvalid) fuse_measurement(longint'(sm.baro), reg_val[RegBaroR], GainBaro);
      if (sm.rvalid) fuse_measurement(longint'(sm.rng), reg_val[RegRangeR], GainRange);
      if (est_spd > lim) est_spd = lim;
      else if (est_spd < -lim) est_spd = -lim;
      if (est_alt < 0) begin
        est_alt = 0;
        if (est_spd < 0) est_spd = 0;
      end
    end
    e.alt = est_alt[30:0];
    e.spd = est_spd[31:0];
    e.taken = taken;
    e.baro_used = taken && sm.bvalid;
    e.range_used = taken && sm.rvalid;
    return e;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // monitor: input, result and register transactions
  always @(posedge clk_i) begin
    estimate_t e;
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        expected_estimates.push_back(predict_estimate(sample_on_bus));
        sample_taken = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i <= RegMaxSpeed) reg_val[cfg_index_i] = longint'(cfg_data_i);
        cfg_done = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        if (expected_estimates.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          e = expected_estimates.pop_front();
          if (m_tdata[30:0] !== e.alt) report_mismatch("altitude", m_tdata[30:0], e.alt);
          if ($signed(m_tdata[62:31]) !== e.spd)
            report_mismatch("vertical_speed", $signed(m_tdata[62:31]), e.spd);
          if (m_tuser[0] !== e.taken) report_mismatch("step_taken", m_tuser[0], e.taken);
          if (m_tuser[1] !== e.baro_used) report_mismatch("baro_used", m_tuser[1], e.baro_used);
          if (m_tuser[2] !== e.range_used)
            report_mismatch("range_used", m_tuser[2], e.range_used);
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no transaction for %0d cycles", StallLimit);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // sample driver
  always @(negedge clk_i) begin
    sample_t sm;
    if (rst_ni && (!s_tvalid || sample_taken)) begin
      sample_taken = 1'b0;
      if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        sm = pending_samples.pop_front();
        sample_on_bus = sm;
        s_tdata <= {3'b0, sm.rvalid, sm.rng, sm.bvalid, sm.baro, sm.dt, sm.accel};
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result ready, with one long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic wait_drained();
    while (pending_samples.size() != 0 || s_tvalid || expected_estimates.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    @(negedge clk_i);
    cfg_done = 1'b0;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(negedge clk_i); while (!cfg_done);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(logic [30:0] g, logic [30:0] q, logic [30:0] rb,
                          logic [30:0] rr, logic [30:0] vmax);
    write_reg(RegGravity, g);
    write_reg(RegQ, q);
    write_reg(RegBaroR, rb);
    write_reg(RegRangeR, rr);
    write_reg(RegMaxSpeed, vmax);
  endtask

  function automatic sample_t make_sample(logic signed [31:0] accel, logic [19:0] dt,
                                          logic signed [31:0] baro, logic bv,
                                          logic [30:0] rng, logic rv);
    sample_t sm;
    sm.accel = accel;
    sm.dt = dt;
    sm.baro = baro;
    sm.bvalid = bv;
    sm.rng = rng;
    sm.rvalid = rv;
    return sm;
  endfunction

  function automatic sample_t random_sample();
    sample_t sm;
    int unsigned pick;
    sm.bvalid = 1'($urandom_range(1));
    sm.rvalid = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 10) begin
      case ($urandom_range(4))
        0: sm.dt = 20'd0;
        1: sm.dt = DtMin - 20'd1;
        2: sm.dt = DtMax + 20'd1;
        3: sm.dt = 20'hFFFFF;
        default: sm.dt = 20'($urandom);
      endcase
    end else if (pick < 20) begin
      sm.dt = $urandom_range(1) ? DtMin : DtMax;
    end else begin
      sm.dt = 20'($urandom_range(DtMax, DtMin));
    end
    if ($urandom_range(3) == 0) begin
      sm.accel = $urandom;
      sm.baro = $urandom;
      sm.rng = 31'($urandom);
    end else begin
      // plausible flight values around the current estimate
      sm.accel = $signed($urandom_range(1600000)) - 200000;
      sm.baro = est_alt[31:0] + $signed($urandom_range(2000000)) - 1000000;
      sm.rng = 31'(est_alt[30:0] + $urandom_range(1000000));
    end
    return sm;
  endfunction

  task automatic run_phase(int unsigned n, int unsigned idle_pct, int unsigned stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) pending_samples.push_back(random_sample());
    wait_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 0;
    hold_cnt = 0;
    quiet_cycles = 0;
    error_count = 0;
    sample_taken = 1'b0;
    cfg_done = 1'b0;
    foreach (reg_val[i]) reg_val[i] = 0;
    est_alt = 0;
    est_spd = 0;
    est_var = longint'(OneQ16);
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset settings, then extremes of every field
    pending_samples.push_back(make_sample(32'sd655360, 20'd1000, 32'sd0, 1'b0, 31'd0, 1'b0));
    pending_samples.push_back(make_sample(32'sd655360, 20'd1000, 32'sd65536, 1'b1, 31'd0, 1'b1));
    wait_drained();
    set_regs(31'd642908, 31'd655, 31'd6554, 31'd3277, 31'd655360);
    pending_samples.push_back(make_sample(32'sd0, 20'd0, 32'sd0, 1'b1, 31'd0, 1'b1));
    pending_samples.push_back(make_sample(32'sd0, DtMin - 20'd1, 32'sd0, 1'b1, 31'd0, 1'b1));
    pending_samples.push_back(make_sample(32'sd0, DtMax + 20'd1, 32'sd0, 1'b1, 31'd0, 1'b1));
    pending_samples.push_back(make_sample(32'sd0, 20'hFFFFF, 32'sd0, 1'b0, 31'd0, 1'b0));
    pending_samples.push_back(make_sample(32'sh7FFFFFFF, DtMax, 32'sh7FFFFFFF, 1'b1,
                                          31'h7FFFFFFF, 1'b1));
    pending_samples.push_back(make_sample(32'sh7FFFFFFF, DtMax, 32'sh7FFFFFFF, 1'b1,
                                          31'h7FFFFFFF, 1'b0));
    pending_samples.push_back(make_sample(-32'sh80000000, DtMax, -32'sh80000000, 1'b1,
                                          31'd0, 1'b0));
    pending_samples.push_back(make_sample(-32'sh80000000, DtMin, 32'sd0, 1'b0, 31'd0, 1'b1));
    pending_samples.push_back(make_sample(32'sd642908, DtMin, 32'sd100000, 1'b1,
                                          31'd90000, 1'b1));
    pending_samples.push_back(make_sample(32'sd1000000, 20'd50000, 32'sd0, 1'b0,
                                          31'd200000, 1'b1));
    pending_samples.push_back(make_sample(-32'sd5000000, 20'd80000, -32'sd300000, 1'b1,
                                          31'd0, 1'b0));
    wait_drained();
    // zero noise: first correction drives the variance to zero, then the gain vanishes
    set_regs(31'd0, 31'd0, 31'd0, 31'd0, 31'h7FFFFFFF);
    pending_samples.push_back(make_sample(32'sd0, 20'd1000, 32'sd500000, 1'b1, 31'd0, 1'b0));
    pending_samples.push_back(make_sample(32'sd0, 20'd1000, 32'sd900000, 1'b1,
                                          31'd700000, 1'b1));
    pending_samples.push_back(make_sample(32'sd0, 20'd1000, 32'sd0, 1'b0, 31'd10, 1'b1));
    wait_drained();
    write_reg(RegUnused, 31'h7FFFFFFF);
    write_reg(3'd7, 31'd12345);
    pending_samples.push_back(make_sample(32'sd65536, 20'd2000, 32'sd0, 1'b1, 31'd0, 1'b1));
    wait_drained();

    // random phases over a spread of settings and idling
    set_regs(31'd642908, 31'd655, 31'd6554, 31'd3277, 31'd655360);
    run_phase(160, 0, 0);
    run_phase(160, 56, 0);
    set_regs(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
    run_phase(120, 0, 56);
    set_regs(31'd0, 31'd1, 31'd0, 31'd20, 31'd0);
    run_phase(120, 30, 30);
    set_regs(31'($urandom), 31'($urandom_range(70000)), 31'($urandom_range(600000)),
             31'($urandom_range(600000)), 31'($urandom_range(3000000)));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 400;
    repeat (60) pending_samples.push_back(random_sample());
    wait_drained();
    run_phase(110, 30, 30);
    set_regs(31'd642908, 31'd3000, 31'd20000, 31'd8000, 31'd2000000);
    run_phase(100, 56, 56);
    run_phase(100, 0, 0);

    wait_drained();
    if (expected_estimates.size() != 0) report_mismatch("results missing", 0,
                                                        expected_estimates.size());
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: altitude_kalman_estimator.f
rtl/ake_pkg.sv
rtl/ake_front.sv
rtl/ake_div.sv
rtl/ake_back.sv
rtl/altitude_kalman_estimator.sv
verif/altitude_kalman_estimator_test.sv
